### sv/kwm_pkg.sv
// kwm_pkg: beat types shared by the k-way merge block
// standalone, no dependencies
`default_nettype none

package kwm_pkg;

  localparam int unsigned ListIndexW = 2;
  localparam int unsigned ValueW     = 32;

  // one load beat
  typedef struct packed {
    logic [ListIndexW-1:0]   list_index;
    logic signed [ValueW-1:0] value;
    logic                    last_of_load;
  } in_beat_t;

  // one merged result beat
  typedef struct packed {
    logic [ListIndexW-1:0]   source_list;
    logic signed [ValueW-1:0] merged_value;
    logic                    last_result;
    logic                    dropped;
  } out_beat_t;

endpackage

`default_nettype wire

### sv/kwm_ram.sv
// kwm_ram: generic single-write, single-read ram with registered read data
// standalone, no dependencies
`default_nettype none

module kwm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/k_way_sorted_list_merge_top.sv
// k_way_sorted_list_merge_top: loads up to LISTS sorted lists, then merges them
// depends on kwm_pkg (beat types) and kwm_ram (element store)
`default_nettype none

//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   load    | in        | in_valid_i / in_stall_o   | kwm_pkg::in_beat_t
//   merged  | out       | out_valid_o / out_stall_i | kwm_pkg::out_beat_t
//
// load phase: one beat per cycle; beats that fit their list go into the store ram
// merge phase: per result the sequencer walks the lists with one read port and
//   one signed comparator, an issue and a compare state per non-empty list, only
//   the issue state per exhausted list, plus the emit state
// load stalls from the last beat of a non-empty load until the final result leaves
// out_stall_i holds the current result; the scan resumes once it is taken
// reset clears fill counts, read pointers, drop flag and sequencer; ram is not cleared

module k_way_sorted_list_merge_top #(
  parameter int unsigned LISTS      = 4,
  parameter int unsigned LIST_DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire kwm_pkg::in_beat_t   in_beat_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output kwm_pkg::out_beat_t       out_beat_o
);

  import kwm_pkg::*;

  localparam int unsigned StoreDepth = LISTS * LIST_DEPTH;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned LiW        = $clog2(LISTS);
  localparam int unsigned CntW       = $clog2(LIST_DEPTH + 1);
  localparam int unsigned TotW       = $clog2(StoreDepth + 1);

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_CMP   = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  logic [CntW-1:0]          fill_q [LISTS];
  logic [CntW-1:0]          fill_d [LISTS];
  logic [CntW-1:0]          rptr_q [LISTS];
  logic [CntW-1:0]          rptr_d [LISTS];
  logic                     ovf_q, ovf_d;
  logic [TotW-1:0]          total_q, total_d;
  logic [TotW-1:0]          count_q, count_d;
  logic [LiW-1:0]           scan_q, scan_d;
  logic [LiW-1:0]           best_idx_q, best_idx_d;
  logic signed [ValueW-1:0] best_val_q, best_val_d;
  logic                     found_q, found_d;

  // load side
  logic                     in_acc;
  logic                     li_ok;
  logic [LiW-1:0]           li_idx;
  logic [CntW-1:0]          fill_at_li;
  logic                     store_ok;
  logic [AddrW-1:0]         waddr;

  // merge side
  logic                     head_live;
  logic                     ram_re;
  logic [AddrW-1:0]         raddr;
  logic [ValueW-1:0]        rdata;
  logic signed [ValueW-1:0] head_val;
  logic                     scan_end;
  logic                     is_last;
  logic                     out_acc;

  assign in_stall_o  = (state_q != S_LOAD);
  assign in_acc      = in_valid_i && (state_q == S_LOAD);
  assign li_ok       = {1'b0, in_beat_i.list_index} < 3'(LISTS);
  assign li_idx      = LiW'(in_beat_i.list_index);
  assign fill_at_li  = li_ok ? fill_q[li_idx] : '0;
  assign store_ok    = li_ok && (fill_at_li < CntW'(LIST_DEPTH));
  assign waddr       = AddrW'(int'(li_idx) * LIST_DEPTH + int'(fill_at_li));

  assign head_live   = rptr_q[scan_q] < fill_q[scan_q];
  assign ram_re      = (state_q == S_ISSUE) && head_live;
  assign raddr       = AddrW'(int'(scan_q) * LIST_DEPTH + int'(rptr_q[scan_q]));
  assign head_val    = $signed(rdata);
  assign scan_end    = (scan_q == LiW'(LISTS - 1));
  assign is_last     = (count_q + TotW'(1)) == total_q;

  assign out_valid_o = (state_q == S_EMIT);
  assign out_acc     = out_valid_o && !out_stall_i;

  // result beat straight from the scan registers, steady while in S_EMIT
  assign out_beat_o.source_list  = ListIndexW'(best_idx_q);
  assign out_beat_o.merged_value = best_val_q;
  assign out_beat_o.last_result  = is_last;
  assign out_beat_o.dropped      = ovf_q;

  kwm_ram #(
    .WIDTH (ValueW),
    .DEPTH (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && store_ok),
    .waddr_i (waddr),
    .wdata_i (in_beat_i.value),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    rptr_d     = rptr_q;
    ovf_d      = ovf_q;
    total_d    = total_q;
    count_d    = count_q;
    scan_d     = scan_q;
    best_idx_d = best_idx_q;
    best_val_d = best_val_q;
    found_d    = found_q;

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (store_ok) begin
            fill_d[li_idx] = fill_at_li + CntW'(1);
            total_d        = total_q + TotW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_beat_i.last_of_load) begin
            if (total_d == '0) begin
              // empty load: nothing to merge, just drop the flag
              ovf_d = 1'b0;
            end else begin
              scan_d  = '0;
              found_d = 1'b0;
              state_d = S_ISSUE;
            end
          end
        end
      end
      S_ISSUE: begin
        if (head_live) begin
          state_d = S_CMP;
        end else if (scan_end) begin
          state_d = S_EMIT;
        end else begin
          scan_d = scan_q + LiW'(1);
        end
      end
      S_CMP: begin
        // strict less-than keeps the lower list on equal heads
        if (!found_q || (head_val < best_val_q)) begin
          found_d    = 1'b1;
          best_idx_d = scan_q;
          best_val_d = head_val;
        end
        if (scan_end) begin
          state_d = S_EMIT;
        end else begin
          scan_d  = scan_q + LiW'(1);
          state_d = S_ISSUE;
        end
      end
      S_EMIT: begin
        if (out_acc) begin
          if (is_last) begin
            for (int l = 0; l < LISTS; l++) begin
              fill_d[l] = '0;
              rptr_d[l] = '0;
            end
            ovf_d   = 1'b0;
            total_d = '0;
            count_d = '0;
            state_d = S_LOAD;
          end else begin
            rptr_d[best_idx_q] = rptr_q[best_idx_q] + CntW'(1);
            count_d = count_q + TotW'(1);
            scan_d  = '0;
            found_d = 1'b0;
            state_d = S_ISSUE;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      for (int l = 0; l < LISTS; l++) begin
        fill_q[l] <= '0;
        rptr_q[l] <= '0;
      end
      ovf_q   <= 1'b0;
      total_q <= '0;
      count_q <= '0;
      scan_q  <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      rptr_q  <= rptr_d;
      ovf_q   <= ovf_d;
      total_q <= total_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      found_q <= found_d;
    end
  end

  // best-head payload, no reset needed
  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
  end

endmodule

`default_nettype wire
